>>> design/frts_pkg.sv
package frts_pkg;

    localparam int MAX_MEMBERS_DEF = 32;
    localparam int FIT_W           = 32;
    localparam int IDX_OUT_W       = 5;
    localparam int KEEP_SHIFT      = 1;

    typedef struct packed {
        logic signed [FIT_W-1:0] fitness;
        logic                    final_member;
    } t_in;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]    member_index;
        logic signed [FIT_W-1:0] ranked_fitness;
        logic                    survivor;
        logic                    end_of_ranking;
    } t_out;

    typedef struct packed {
        logic load;
        logic unload;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_state;

endpackage

>>> design/frts_cell.sv
module frts_cell #(
    parameter int IW = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  frts_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [frts_pkg::FIT_W-1:0] i_new_fit,
    input  logic [IW-1:0]                     i_new_idx,
    input  logic                              i_left_take,
    input  logic                              i_left_valid,
    input  logic signed [frts_pkg::FIT_W-1:0] i_left_fit,
    input  logic [IW-1:0]                     i_left_idx,
    input  logic                              i_right_valid,
    input  logic signed [frts_pkg::FIT_W-1:0] i_right_fit,
    input  logic [IW-1:0]                     i_right_idx,
    output logic                              o_take,
    output logic                              o_valid,
    output logic signed [frts_pkg::FIT_W-1:0] o_fit,
    output logic [IW-1:0]                     o_idx
);

    logic                              r_valid, n_valid;
    logic signed [frts_pkg::FIT_W-1:0] r_fit, n_fit;
    logic [IW-1:0]                     r_idx, n_idx;

    // a new value goes behind every held value that is greater or equal
    assign o_take = !r_valid || (r_fit < i_new_fit);

    always_comb begin
        n_valid = r_valid;
        n_fit   = r_fit;
        n_idx   = r_idx;
        priority if (i_ctrl.unload) begin
            n_valid = i_right_valid;
            n_fit   = i_right_fit;
            n_idx   = i_right_idx;
        end else if (i_ctrl.load && o_take) begin
            if (i_left_take) begin
                n_valid = i_left_valid;
                n_fit   = i_left_fit;
                n_idx   = i_left_idx;
            end else begin
                n_valid = 1'b1;
                n_fit   = i_new_fit;
                n_idx   = i_new_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fit <= n_fit;
        r_idx <= n_idx;
    end

    assign o_valid = r_valid;
    assign o_fit   = r_fit;
    assign o_idx   = r_idx;

endmodule

>>> design/fitness_rank_truncation_select.sv
// a non-final item is taken while busy is low, and busy stays low
// a final item starts the ranking: n results follow, one per cycle, the first
// after the state and output registers; busy is high while they are produced
// throughput: one member per cycle while loading, set by the sorted cell row
// synchronous active-low reset empties the row and zeroes the member count
// the receiver cannot stall: each result is shown for one cycle only
module fitness_rank_truncation_select #(
    parameter int MAX_MEMBERS = frts_pkg::MAX_MEMBERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  frts_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_valid,
    output frts_pkg::t_out o_result
);

    localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW = $clog2(MAX_MEMBERS + 1);

    frts_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rank, n_rank;
    logic                 r_out_valid, n_out_valid;
    frts_pkg::t_out       r_out, n_out;

    frts_pkg::t_cell_ctrl ctrl;
    logic                 accept;
    logic                 room;
    logic [CW-1:0]        keep_raw, keep;
    logic [CW-1:0]        rank_inc;
    logic                 last_rank;
    logic [IW+frts_pkg::IDX_OUT_W-1:0] idx_ext;

    logic [MAX_MEMBERS-1:0]            c_take;
    logic [MAX_MEMBERS-1:0]            c_valid;
    logic signed [frts_pkg::FIT_W-1:0] c_fit [MAX_MEMBERS];
    logic [IW-1:0]                     c_idx [MAX_MEMBERS];

    assign busy   = (r_state == frts_pkg::S_EMIT);
    assign accept = start && !busy;
    assign room   = (r_count < CW'(MAX_MEMBERS));

    assign ctrl.load   = accept && room;
    assign ctrl.unload = busy;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_MEMBERS; gi++) begin : g_cell
            logic                              left_take;
            logic                              left_valid;
            logic signed [frts_pkg::FIT_W-1:0] left_fit;
            logic [IW-1:0]                     left_idx;
            logic                              right_valid;
            logic signed [frts_pkg::FIT_W-1:0] right_fit;
            logic [IW-1:0]                     right_idx;

            if (gi == 0) begin : g_head
                assign left_take  = 1'b0;
                assign left_valid = 1'b0;
                assign left_fit   = '0;
                assign left_idx   = '0;
            end else begin : g_mid
                assign left_take  = c_take[gi-1];
                assign left_valid = c_valid[gi-1];
                assign left_fit   = c_fit[gi-1];
                assign left_idx   = c_idx[gi-1];
            end

            if (gi == MAX_MEMBERS - 1) begin : g_tail
                assign right_valid = 1'b0;
                assign right_fit   = '0;
                assign right_idx   = '0;
            end else begin : g_body
                assign right_valid = c_valid[gi+1];
                assign right_fit   = c_fit[gi+1];
                assign right_idx   = c_idx[gi+1];
            end

            frts_cell #(
                .IW(IW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_new_fit    (i_item.fitness),
                .i_new_idx    (r_count[IW-1:0]),
                .i_left_take  (left_take),
                .i_left_valid (left_valid),
                .i_left_fit   (left_fit),
                .i_left_idx   (left_idx),
                .i_right_valid(right_valid),
                .i_right_fit  (right_fit),
                .i_right_idx  (right_idx),
                .o_take       (c_take[gi]),
                .o_valid      (c_valid[gi]),
                .o_fit        (c_fit[gi]),
                .o_idx        (c_idx[gi])
            );
        end
    endgenerate

    assign keep_raw  = r_count >> frts_pkg::KEEP_SHIFT;
    assign keep      = (keep_raw == '0) ? CW'(1) : keep_raw;
    assign rank_inc  = r_rank + CW'(1);
    assign last_rank = (rank_inc == r_count);
    assign idx_ext   = {{frts_pkg::IDX_OUT_W{1'b0}}, c_idx[0]};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rank      = r_rank;
        n_out_valid = 1'b0;
        n_out       = r_out;
        unique case (r_state)
            frts_pkg::S_LOAD: begin
                if (ctrl.load) begin
                    n_count = r_count + CW'(1);
                end
                if (accept && i_item.final_member) begin
                    n_state = frts_pkg::S_EMIT;
                    n_rank  = '0;
                end
            end
            frts_pkg::S_EMIT: begin
                n_out_valid         = 1'b1;
                n_out.member_index  = idx_ext[frts_pkg::IDX_OUT_W-1:0];
                n_out.ranked_fitness = c_fit[0];
                n_out.survivor      = (r_rank < keep);
                n_out.end_of_ranking = last_rank;
                n_rank              = rank_inc;
                if (last_rank) begin
                    n_state = frts_pkg::S_LOAD;
                    n_count = '0;
                    n_rank  = '0;
                end
            end
            default: begin
                n_state = frts_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frts_pkg::S_LOAD;
            r_count     <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rank      <= n_rank;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_emit_has_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_count != '0) && c_valid[0])
        else $error("ranking with an empty cell row");

    a_emit_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_rank < r_count))
        else $error("rank counter past member count");

    a_end_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.end_of_ranking) |-> !busy && (r_count == '0))
        else $error("block still busy after the last ranked member");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result transfer outside ranking");

    a_plain_item_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_item.final_member) |=> !busy)
        else $error("non-final item started a ranking");
`endif

endmodule
